>>> design/lfu_pkg.sv
package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W      = IDX_W;
    localparam int HELD_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (HELD_W > CAP_W) ? HELD_W : CAP_W;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [IDX_W-1:0]      found_idx;
        logic [RANK_W-1:0]     found_rank;
        logic [31:0]           found_value;
        logic                  vic_valid;
        logic [IDX_W-1:0]      vic_idx;
        logic [COUNT_BITS-1:0] vic_count;
        logic [RANK_W-1:0]     vic_rank;
        logic [31:0]           vic_key;
        logic                  free_valid;
        logic [IDX_W-1:0]      free_idx;
    } lfu_token_t;

    // Update command broadcast to every cell
    typedef struct packed {
        logic              en;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              write_value;
        logic              evict;
        logic [IDX_W-1:0]  vic_idx;
        logic [RANK_W-1:0] vic_rank;
        logic              insert;
        logic [IDX_W-1:0]  ins_idx;
        logic [31:0]       key;
        logic [31:0]       value;
    } lfu_update_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lfu_state_t;

endpackage

>>> design/lfu_cell.sv
module lfu_cell
    import lfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [31:0]       req_key,
    input  lfu_token_t        tok_in,
    output lfu_token_t        tok_out,
    input  lfu_update_t       upd
);

    logic                  valid_reg;
    logic [31:0]           key_reg;
    logic [31:0]           value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [RANK_W-1:0]     rank_reg;
    lfu_token_t            tok_reg;
    lfu_token_t            tok_next;

    logic                  valid_next;
    logic [31:0]           key_next;
    logic [31:0]           value_next;
    logic [COUNT_BITS-1:0] count_next;
    logic [RANK_W-1:0]     rank_next;

    // Fold this slot into the passing token
    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg && key_reg == req_key && !tok_in.found)
        begin
            tok_next.found       = 1'b1;
            tok_next.found_idx   = cell_idx;
            tok_next.found_rank  = rank_reg;
            tok_next.found_value = value_reg;
        end
        if (valid_reg && (!tok_in.vic_valid || count_reg < tok_in.vic_count ||
            (count_reg == tok_in.vic_count && rank_reg > tok_in.vic_rank)))
        begin
            tok_next.vic_valid = 1'b1;
            tok_next.vic_idx   = cell_idx;
            tok_next.vic_count = count_reg;
            tok_next.vic_rank  = rank_reg;
            tok_next.vic_key   = key_reg;
        end
        if (!valid_reg && !tok_in.free_valid)
        begin
            tok_next.free_valid = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    // Apply the broadcast update to this slot
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        if (upd.en)
        begin
            if (upd.hit)
            begin
                if (cell_idx == upd.hit_idx)
                begin
                    if (count_reg != {COUNT_BITS{1'b1}})
                        count_next = count_reg + COUNT_BITS'(1);
                    rank_next = '0;
                    if (upd.write_value)
                        value_next = upd.value;
                end
                else if (valid_reg && rank_reg < upd.hit_rank)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            else if (upd.insert && cell_idx == upd.ins_idx)
            begin
                valid_next = 1'b1;
                key_next   = upd.key;
                value_next = upd.value;
                count_next = COUNT_BITS'(1);
                rank_next  = '0;
            end
            else if (upd.evict && cell_idx == upd.vic_idx)
            begin
                valid_next = 1'b0;
            end
            else if (valid_reg)
            begin
                rank_next = rank_reg
                          - RANK_W'(upd.evict && rank_reg > upd.vic_rank)
                          + RANK_W'(upd.insert);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> design/lfu_cache_lru_tiebreak.sv
// Fully associative key/value cache with least-frequently-used replacement,
// ties going to the least recently touched entry. Each slot lives in a cell
// of a chain; a request sends a token down the chain, one cell per cycle,
// that collects the key match, the replacement victim and the first free
// slot, and then the update is broadcast to all cells. The time from
// acceptance to result grows with the length of the cell chain; the next
// request is taken once the result is registered. The valid bits clear at
// reset, so there is no clearing pass. The capacity set through cfg_wdata
// reads 0 as 1 and saturates at MAX_ENTRIES; write it only while idle.
module lfu_cache_lru_tiebreak
    import lfu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] read_value,
    output logic               evicted,
    output logic signed [31:0] evicted_key,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata
);

    lfu_state_t        state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [HELD_W-1:0] held_reg, held_next;
    logic              put_reg;
    logic [31:0]       key_reg;
    logic [31:0]       value_reg;
    lfu_token_t        res_reg;
    lfu_token_t        tok [MAX_ENTRIES+1];
    lfu_update_t       upd;

    logic              out_valid_reg;
    logic              hit_reg;
    logic [31:0]       read_value_reg;
    logic              evicted_reg;
    logic [31:0]       evicted_key_reg;

    logic              accept;
    logic              start_reg;
    logic              fire;
    logic              full;
    logic              evict;
    logic              insert;
    logic [CMP_W-1:0]  eff_cap;

    assign accept = in_valid && !in_stall;

    // Inject a fresh token at the head of the chain once the key is held
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = start_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            lfu_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(g)),
                .req_key  (key_reg),
                .tok_in   (tok[g]),
                .tok_out  (tok[g+1]),
                .upd      (upd)
            );
        end
    endgenerate

    // Effective capacity and full test
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES))
            eff_cap = CMP_W'(MAX_ENTRIES);
        else
            eff_cap = CMP_W'(cap_reg);
    end

    assign full   = CMP_W'(held_reg) >= eff_cap;
    assign evict  = put_reg && !res_reg.found && full && res_reg.vic_valid;
    assign insert = put_reg && !res_reg.found && (evict || res_reg.free_valid);

    // Build the update command
    always_comb
    begin
        upd             = '0;
        upd.en          = fire;
        upd.hit         = res_reg.found;
        upd.hit_idx     = res_reg.found_idx;
        upd.hit_rank    = res_reg.found_rank;
        upd.write_value = put_reg;
        upd.evict       = evict;
        upd.vic_idx     = res_reg.vic_idx;
        upd.vic_rank    = res_reg.vic_rank;
        upd.insert      = insert;
        upd.ins_idx     = evict ? res_reg.vic_idx : res_reg.free_idx;
        upd.key         = key_reg;
        upd.value       = value_reg;
    end

    // Next state and handshake
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        fire       = 1'b0;
        held_next  = held_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok[MAX_ENTRIES].valid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fire       = 1'b1;
                    held_next  = held_reg - HELD_W'(evict) + HELD_W'(insert);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_W'(16);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            start_reg <= accept;
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the request, the scan result and the output
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            put_reg   <= mode;
            key_reg   <= key;
            value_reg <= value;
        end
        if (state_reg == ST_SCAN && tok[MAX_ENTRIES].valid)
            res_reg <= tok[MAX_ENTRIES];
        if (fire)
        begin
            hit_reg         <= res_reg.found;
            read_value_reg  <= put_reg ? 32'd0
                             : (res_reg.found ? res_reg.found_value : 32'hFFFF_FFFF);
            evicted_reg     <= evict;
            evicted_key_reg <= evict ? res_reg.vic_key : 32'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule
